// File: rtl/gmuf_pkg.sv
// Package for the grid maze union-find carver.
// Holds the direction and register codes, the sequencer states and the passage masks.
// Depends on nothing.
`default_nettype none

package gmuf_pkg;

	localparam int DEF_MAX_WIDTH  = 64;
	localparam int DEF_MAX_HEIGHT = 64;

	localparam int CFG_W  = 7;
	localparam int EXT_W  = 10;
	localparam int COORD_W = 6;

	localparam logic [CFG_W-1:0] GRID_RESET = 7'd64;

	localparam logic [1:0] DIR_NORTH = 2'd0;
	localparam logic [1:0] DIR_SOUTH = 2'd1;
	localparam logic [1:0] DIR_EAST  = 2'd2;
	localparam logic [1:0] DIR_WEST  = 2'd3;

	localparam logic CFG_WIDTH_IDX  = 1'b0;
	localparam logic CFG_HEIGHT_IDX = 1'b1;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_CHECK,
		ST_WALK_A,
		ST_WALK_B,
		ST_UPD_A,
		ST_UPD_B,
		ST_FINISH
	} state_t;

	function automatic logic [3:0] dir_mask(input logic [1:0] d);
		logic [3:0] m;
		case (d)
			DIR_NORTH: m = 4'b0001;
			DIR_SOUTH: m = 4'b0010;
			DIR_EAST:  m = 4'b0100;
			DIR_WEST:  m = 4'b1000;
			default:   m = 4'b0000;
		endcase
		return m;
	endfunction

	function automatic logic [3:0] dir_opposite(input logic [1:0] d);
		logic [3:0] m;
		case (d)
			DIR_NORTH: m = 4'b0010;
			DIR_SOUTH: m = 4'b0001;
			DIR_EAST:  m = 4'b1000;
			DIR_WEST:  m = 4'b0100;
			default:   m = 4'b0000;
		endcase
		return m;
	endfunction

endpackage

`default_nettype wire

// File: rtl/grid_maze_union_find_carver.sv
// Top level of the grid maze union-find carver: parent and passage memories and their sequencer.
// Depends on gmuf_pkg for codes, states and passage masks.
//
// Channel  Direction  Handshake              Payload
// in       input      in_valid / in_ready    cell_x, cell_y, direction
// out      output     out_valid / out_ready  carved, out_of_grid, cell_passages, neighbor_passages
// cfg      input      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// An in-grid item passes the bounds check, walks the trees of its two cells to their roots
// with one parent memory read per step, then reads both passage words and, on a carve,
// updates them and links the roots; an out-of-grid item goes from the check to the last step.
// After reset a clearing pass writes every cell while in_ready stays low; configuration
// writes are taken at any time. A result waits in the output register; the block stalls in its
// last step only while that register is still full.
`default_nettype none

module grid_maze_union_find_carver
	import gmuf_pkg::*;
#(
	parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic [COORD_W-1:0] cell_x,
	input  wire logic [COORD_W-1:0] cell_y,
	input  wire logic [1:0]         direction,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic                    carved,
	output logic                    out_of_grid,
	output logic [3:0]              cell_passages,
	output logic [3:0]              neighbor_passages,
	input  wire logic               cfg_valid,
	output logic                    cfg_ready,
	input  wire logic               cfg_index,
	input  wire logic [CFG_W-1:0]   cfg_data
);

	localparam int CELL_COUNT = MAX_WIDTH * MAX_HEIGHT;
	localparam int ADDR_W     = $clog2(CELL_COUNT);
	localparam logic [ADDR_W-1:0] LAST_CELL = ADDR_W'(CELL_COUNT - 1);

	logic [ADDR_W-1:0] par_mem [CELL_COUNT];
	logic [3:0]        pas_mem [CELL_COUNT];

	state_t state_q, state_d;

	logic [CFG_W-1:0]   width_q, height_q;
	logic [COORD_W-1:0] x_q, y_q;
	logic [1:0]         d_q;
	logic [ADDR_W-1:0]  clr_q, cur_q, a_q, b_q, ra_q, rb_q;
	logic               carve_q, oob_q;
	logic [3:0]         pa_q, pb_q;
	logic               out_valid_q, carved_q, out_oob_q;
	logic [3:0]         out_pa_q, out_pb_q;

	logic [ADDR_W-1:0]  par_rdata_q, par_rd_addr, par_wa, par_wd;
	logic [3:0]         pas_rdata_q, pas_wd;
	logic [ADDR_W-1:0]  pas_rd_addr, pas_wa;
	logic               par_we, pas_we;

	logic [EXT_W-1:0] w_use, h_use, x_ext, y_ext, nx_ext, ny_ext;
	logic             oob;
	logic [ADDR_W-1:0] a_idx, b_idx;
	logic             out_free, root_hit;
	logic [3:0]       new_pa, new_pb;

	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign carved = carved_q;
	assign out_of_grid = out_oob_q;
	assign cell_passages = out_pa_q;
	assign neighbor_passages = out_pb_q;
	assign out_free = !out_valid_q || out_ready;
	assign root_hit = (par_rdata_q == cur_q);

	always_comb begin
		w_use = (EXT_W'(width_q) > EXT_W'(MAX_WIDTH)) ? EXT_W'(MAX_WIDTH) : EXT_W'(width_q);
		h_use = (EXT_W'(height_q) > EXT_W'(MAX_HEIGHT)) ? EXT_W'(MAX_HEIGHT) : EXT_W'(height_q);
		x_ext = EXT_W'(x_q);
		y_ext = EXT_W'(y_q);
		nx_ext = x_ext;
		ny_ext = y_ext;
		oob = (x_ext >= w_use) || (y_ext >= h_use);
		case (d_q)
			DIR_NORTH: begin
				ny_ext = y_ext - EXT_W'(1);
				oob = oob || (y_q == '0);
			end
			DIR_SOUTH: begin
				ny_ext = y_ext + EXT_W'(1);
				oob = oob || (ny_ext >= h_use);
			end
			DIR_EAST: begin
				nx_ext = x_ext + EXT_W'(1);
				oob = oob || (nx_ext >= w_use);
			end
			DIR_WEST: begin
				nx_ext = x_ext - EXT_W'(1);
				oob = oob || (x_q == '0);
			end
			default: oob = 1'b1;
		endcase
		a_idx = ADDR_W'(int'(y_ext) * MAX_WIDTH + int'(x_ext));
		b_idx = ADDR_W'(int'(ny_ext) * MAX_WIDTH + int'(nx_ext));
		new_pa = pas_rdata_q | (carve_q ? dir_mask(d_q) : 4'b0000);
		new_pb = pas_rdata_q | (carve_q ? dir_opposite(d_q) : 4'b0000);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		in_ready = 1'b0;
		par_rd_addr = cur_q;
		pas_rd_addr = a_q;
		par_we = 1'b0;
		par_wa = rb_q;
		par_wd = a_q;
		pas_we = 1'b0;
		pas_wa = a_q;
		pas_wd = new_pa;
		case (state_q)
			ST_CLEAR: begin
				par_we = 1'b1;
				par_wa = clr_q;
				par_wd = clr_q;
				pas_we = 1'b1;
				pas_wa = clr_q;
				pas_wd = 4'b0000;
				if (clr_q == LAST_CELL) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					state_d = ST_CHECK;
				end
			end
			ST_CHECK: begin
				par_rd_addr = a_idx;
				state_d = oob ? ST_FINISH : ST_WALK_A;
			end
			ST_WALK_A: begin
				if (root_hit) begin
					par_rd_addr = b_q;
					state_d = ST_WALK_B;
				end else begin
					par_rd_addr = par_rdata_q;
				end
			end
			ST_WALK_B: begin
				par_rd_addr = par_rdata_q;
				if (root_hit) begin
					pas_rd_addr = a_q;
					state_d = ST_UPD_A;
				end
			end
			ST_UPD_A: begin
				pas_rd_addr = b_q;
				pas_we = carve_q;
				pas_wa = a_q;
				pas_wd = new_pa;
				state_d = ST_UPD_B;
			end
			ST_UPD_B: begin
				pas_we = carve_q;
				pas_wa = b_q;
				pas_wd = new_pb;
				par_we = carve_q;
				par_wa = rb_q;
				par_wd = a_q;
				state_d = ST_FINISH;
			end
			ST_FINISH: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		par_rdata_q <= par_mem[par_rd_addr];
		pas_rdata_q <= pas_mem[pas_rd_addr];
		if (par_we) begin
			par_mem[par_wa] <= par_wd;
		end
		if (pas_we) begin
			pas_mem[pas_wa] <= pas_wd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q <= GRID_RESET;
			height_q <= GRID_RESET;
			clr_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_WIDTH_IDX:  width_q <= cfg_data;
					CFG_HEIGHT_IDX: height_q <= cfg_data;
					default: ;
				endcase
			end
			if (state_q == ST_CLEAR) begin
				clr_q <= clr_q + ADDR_W'(1);
			end
			if (state_q == ST_FINISH && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				x_q <= cell_x;
				y_q <= cell_y;
				d_q <= direction;
			end
			ST_CHECK: begin
				cur_q <= a_idx;
				a_q <= a_idx;
				b_q <= b_idx;
				oob_q <= oob;
				carve_q <= 1'b0;
				pa_q <= 4'b0000;
				pb_q <= 4'b0000;
			end
			ST_WALK_A: begin
				if (root_hit) begin
					ra_q <= cur_q;
					cur_q <= b_q;
				end else begin
					cur_q <= par_rdata_q;
				end
			end
			ST_WALK_B: begin
				if (root_hit) begin
					rb_q <= cur_q;
					carve_q <= (cur_q != ra_q);
				end else begin
					cur_q <= par_rdata_q;
				end
			end
			ST_UPD_A: pa_q <= new_pa;
			ST_UPD_B: pb_q <= new_pb;
			ST_FINISH: begin
				if (out_free) begin
					carved_q <= carve_q;
					out_oob_q <= oob_q;
					out_pa_q <= pa_q;
					out_pb_q <= pb_q;
				end
			end
			default: ;
		endcase
	end

	a_accept_goes_check: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> (state_q == ST_CHECK))
		else $error("accepted item did not start the bounds check");

	a_walk_cells_differ: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WALK_A || state_q == ST_WALK_B) |-> (a_q != b_q))
		else $error("edge cell and neighbor share one index");

	a_link_only_on_carve: assert property (@(posedge clk) disable iff (!arst_n)
		(par_we && state_q != ST_CLEAR) |-> (carve_q && rb_q != ra_q))
		else $error("parent written without a carve");

	a_oob_result_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_of_grid) |-> (!carved && cell_passages == 4'b0000
			&& neighbor_passages == 4'b0000))
		else $error("out-of-grid result carries passages");

endmodule

`default_nettype wire

// File: test/gmuf_checker.sv
`timescale 1ns / 1ps
// Result checker for the grid maze union-find carver: watches the input, output and register
// channels, predicts every result from its own parent and passage stores, and counts mismatches.
// Depends on gmuf_pkg for the field widths, direction codes and register indexes.

module gmuf_checker
	import gmuf_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	input  wire logic               in_ready,
	input  wire logic [COORD_W-1:0] cell_x,
	input  wire logic [COORD_W-1:0] cell_y,
	input  wire logic [1:0]         direction,
	input  wire logic               out_valid,
	input  wire logic               out_ready,
	input  wire logic               carved,
	input  wire logic               out_of_grid,
	input  wire logic [3:0]         cell_passages,
	input  wire logic [3:0]         neighbor_passages,
	input  wire logic               cfg_valid,
	input  wire logic               cfg_ready,
	input  wire logic               cfg_index,
	input  wire logic [CFG_W-1:0]   cfg_data,
	output int                      mismatches,
	output int                      outstanding
);

	localparam int GRID_MAX_W = DEF_MAX_WIDTH;
	localparam int GRID_MAX_H = DEF_MAX_HEIGHT;
	localparam int CELLS      = GRID_MAX_W * GRID_MAX_H;

	typedef struct packed {
		logic       carved;
		logic       out_of_grid;
		logic [3:0] cell_open;
		logic [3:0] nbr_open;
	} edge_result_t;

	logic [11:0]      parent_tab [CELLS];
	logic [3:0]       open_tab   [CELLS];
	logic [CFG_W-1:0] grid_w;
	logic [CFG_W-1:0] grid_h;
	edge_result_t     predicted_carves [$];

	function automatic int root_of(input int idx);
		int steps;
		int cur;
		cur = idx;
		for (steps = 0; steps < CELLS; steps++) begin
			if (int'(parent_tab[cur]) == cur)
				break;
			cur = int'(parent_tab[cur]);
		end
		return cur;
	endfunction

	function automatic logic [3:0] side_mask(input logic [1:0] d);
		return 4'b0001 << d;
	endfunction

	function automatic logic [1:0] facing_side(input logic [1:0] d);
		case (d)
			DIR_NORTH: return DIR_SOUTH;
			DIR_SOUTH: return DIR_NORTH;
			DIR_EAST:  return DIR_WEST;
			default:   return DIR_EAST;
		endcase
	endfunction

	// Updates the stores for one edge and returns the result the block must report.
	function automatic edge_result_t carve_edge(input logic [COORD_W-1:0] x,
			input logic [COORD_W-1:0] y, input logic [1:0] d);
		edge_result_t res;
		int w, h, cx, cy, nx, ny, a, b, ra, rb;
		w  = (grid_w > GRID_MAX_W) ? GRID_MAX_W : int'(grid_w);
		h  = (grid_h > GRID_MAX_H) ? GRID_MAX_H : int'(grid_h);
		cx = int'(x);
		cy = int'(y);
		nx = cx + ((d == DIR_EAST) ? 1 : 0) - ((d == DIR_WEST) ? 1 : 0);
		ny = cy + ((d == DIR_SOUTH) ? 1 : 0) - ((d == DIR_NORTH) ? 1 : 0);
		res = '0;
		if (cx >= w || cy >= h || nx < 0 || ny < 0 || nx >= w || ny >= h) begin
			res.out_of_grid = 1'b1;
			return res;
		end
		a  = cy * GRID_MAX_W + cx;
		b  = ny * GRID_MAX_W + nx;
		ra = root_of(a);
		rb = root_of(b);
		if (ra != rb) begin
			parent_tab[rb] = a[11:0];
			open_tab[a] = open_tab[a] | side_mask(d);
			open_tab[b] = open_tab[b] | side_mask(facing_side(d));
			res.carved = 1'b1;
		end
		res.cell_open = open_tab[a];
		res.nbr_open  = open_tab[b];
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		edge_result_t due;
		if (!arst_n) begin
			for (int i = 0; i < CELLS; i++) begin
				parent_tab[i] = i[11:0];
				open_tab[i]   = 4'd0;
			end
			grid_w = GRID_RESET;
			grid_h = GRID_RESET;
			predicted_carves.delete();
			mismatches  = 0;
			outstanding = 0;
		end else begin
			if (out_valid && out_ready) begin
				if (predicted_carves.size() == 0) begin
					$error("result item arrived with no prediction waiting");
					mismatches++;
				end else begin
					due = predicted_carves.pop_front();
					if (carved !== due.carved) begin
						$error("carved: expected %0d, actual %0d", due.carved, carved);
						mismatches++;
					end
					if (out_of_grid !== due.out_of_grid) begin
						$error("out_of_grid: expected %0d, actual %0d",
							due.out_of_grid, out_of_grid);
						mismatches++;
					end
					if (cell_passages !== due.cell_open) begin
						$error("cell_passages: expected %0d, actual %0d",
							due.cell_open, cell_passages);
						mismatches++;
					end
					if (neighbor_passages !== due.nbr_open) begin
						$error("neighbor_passages: expected %0d, actual %0d",
							due.nbr_open, neighbor_passages);
						mismatches++;
					end
				end
			end
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == CFG_WIDTH_IDX)
					grid_w = cfg_data;
				else
					grid_h = cfg_data;
			end
			if (in_valid && in_ready)
				predicted_carves.insert(predicted_carves.size(),
					carve_edge(cell_x, cell_y, direction));
			outstanding = predicted_carves.size();
		end
	end

endmodule

// File: test/tb.sv
`timescale 1ns / 1ps
// Testbench top for the grid maze union-find carver: clock, reset, edge and register stimulus
// under changing idle patterns, and the final verdict.
// Depends on gmuf_pkg, the carver RTL and gmuf_checker.

module tb
	import gmuf_pkg::*;
;

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_ready;
	logic [COORD_W-1:0] cell_x;
	logic [COORD_W-1:0] cell_y;
	logic [1:0]         direction;
	logic               out_valid;
	logic               out_ready;
	logic               carved;
	logic               out_of_grid;
	logic [3:0]         cell_passages;
	logic [3:0]         neighbor_passages;
	logic               cfg_valid;
	logic               cfg_ready;
	logic               cfg_index;
	logic [CFG_W-1:0]   cfg_data;
	int                 mismatches;
	int                 outstanding;

	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int holds_asked   = 0;
	int holds_done    = 0;

	grid_maze_union_find_carver u_top (
		.clk               (clk),
		.arst_n            (arst_n),
		.in_valid          (in_valid),
		.in_ready          (in_ready),
		.cell_x            (cell_x),
		.cell_y            (cell_y),
		.direction         (direction),
		.out_valid         (out_valid),
		.out_ready         (out_ready),
		.carved            (carved),
		.out_of_grid       (out_of_grid),
		.cell_passages     (cell_passages),
		.neighbor_passages (neighbor_passages),
		.cfg_valid         (cfg_valid),
		.cfg_ready         (cfg_ready),
		.cfg_index         (cfg_index),
		.cfg_data          (cfg_data)
	);

	gmuf_checker u_check (
		.clk               (clk),
		.arst_n            (arst_n),
		.in_valid          (in_valid),
		.in_ready          (in_ready),
		.cell_x            (cell_x),
		.cell_y            (cell_y),
		.direction         (direction),
		.out_valid         (out_valid),
		.out_ready         (out_ready),
		.carved            (carved),
		.out_of_grid       (out_of_grid),
		.cell_passages     (cell_passages),
		.neighbor_passages (neighbor_passages),
		.cfg_valid         (cfg_valid),
		.cfg_ready         (cfg_ready),
		.cfg_index         (cfg_index),
		.cfg_data          (cfg_data),
		.mismatches        (mismatches),
		.outstanding       (outstanding)
	);

	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	initial begin
		#10_000_000;
		$display("CHECKS FAILED");
		$finish;
	end

	// Result receiver; a requested hold keeps it stalled for a long stretch.
	initial begin : receiver
		int hold_left;
		hold_left = 0;
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (holds_done != holds_asked) begin
				holds_done++;
				hold_left = 300;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	task automatic send_edge(input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y,
			input logic [1:0] d);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid  <= 1'b1;
		cell_x    <= x;
		cell_y    <= y;
		direction <= d;
		do
			@(posedge clk);
		while (!in_ready);
	endtask

	task automatic drain_results();
		@(negedge clk);
		in_valid <= 1'b0;
		while (outstanding != 0)
			@(negedge clk);
	endtask

	task automatic write_reg(input logic idx, input logic [CFG_W-1:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do
			@(posedge clk);
		while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic set_grid(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h);
		drain_results();
		write_reg(CFG_WIDTH_IDX, w);
		write_reg(CFG_HEIGHT_IDX, h);
	endtask

	// Mostly edges from cells inside the grid in use, with some fully random noise.
	// A requested hold starts once the grid is set, while edges keep coming.
	task automatic carve_phase(input int w, input int h, input int count, input bit hold);
		int ew, eh;
		logic [COORD_W-1:0] x, y;
		ew = (w > DEF_MAX_WIDTH) ? DEF_MAX_WIDTH : w;
		eh = (h > DEF_MAX_HEIGHT) ? DEF_MAX_HEIGHT : h;
		set_grid(w[CFG_W-1:0], h[CFG_W-1:0]);
		if (hold)
			holds_asked++;
		for (int i = 0; i < count; i++) begin
			if (ew > 0 && eh > 0 && $urandom_range(99) < 85) begin
				x = COORD_W'($urandom_range(ew - 1, 0));
				y = COORD_W'($urandom_range(eh - 1, 0));
			end else begin
				x = COORD_W'($urandom_range(63, 0));
				y = COORD_W'($urandom_range(63, 0));
			end
			send_edge(x, y, 2'($urandom_range(3, 0)));
			if (i == count / 2)
				drain_results();
		end
	endtask

	initial begin
		int sched_w [7];
		int sched_h [7];
		int sched_n [7];
		sched_w = '{64, 8, 1, 127, 20, 0, 64};
		sched_h = '{64, 8, 1, 3, 64, 9, 64};
		sched_n = '{150, 60, 15, 60, 80, 15, 40};
		arst_n    = 1'b0;
		in_valid  = 1'b0;
		cell_x    = '0;
		cell_y    = '0;
		direction = DIR_NORTH;
		cfg_valid = 1'b0;
		cfg_index = CFG_WIDTH_IDX;
		cfg_data  = '0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Borders of the full grid, carving and rejoining, then the bound registers.
		send_edge(0, 0, DIR_NORTH);
		send_edge(0, 0, DIR_WEST);
		send_edge(63, 63, DIR_SOUTH);
		send_edge(63, 63, DIR_EAST);
		send_edge(0, 0, DIR_EAST);
		send_edge(1, 0, DIR_WEST);
		send_edge(0, 0, DIR_SOUTH);
		send_edge(0, 1, DIR_NORTH);
		send_edge(63, 63, DIR_NORTH);
		send_edge(63, 62, DIR_WEST);
		send_edge(62, 62, DIR_SOUTH);
		send_edge(62, 63, DIR_EAST);
		set_grid(100, 127);
		send_edge(63, 0, DIR_EAST);
		send_edge(0, 63, DIR_SOUTH);
		send_edge(10, 20, DIR_EAST);
		set_grid(0, 64);
		send_edge(0, 0, DIR_EAST);
		send_edge(5, 5, DIR_NORTH);
		set_grid(8, 4);
		send_edge(8, 2, DIR_WEST);
		send_edge(3, 4, DIR_NORTH);
		send_edge(0, 0, DIR_EAST);
		send_edge(1, 0, DIR_SOUTH);
		send_edge(7, 3, DIR_EAST);

		for (int mode = 0; mode < 3; mode++) begin
			case (mode)
				0: begin
					send_idle_pct = 6;
					recv_idle_pct = 85;
				end
				1: begin
					send_idle_pct = 85;
					recv_idle_pct = 6;
				end
				default: begin
					send_idle_pct = 0;
					recv_idle_pct = 0;
				end
			endcase
			for (int p = 0; p < 7; p++) begin
				carve_phase(sched_w[p], sched_h[p], sched_n[p], (mode == 2 && p == 0));
			end
		end

		drain_results();
		repeat (64) @(posedge clk);
		if (mismatches == 0 && outstanding == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule

// File: grid_maze_union_find_carver.f
rtl/gmuf_pkg.sv
rtl/grid_maze_union_find_carver.sv
test/gmuf_checker.sv
test/tb.sv
